// ===== hdl/blpa_pkg.sv =====
// shared types and constants of the blocked layout pack address generator
package blpa_pkg;

    localparam int ADDR_W      = 28;
    localparam int DEST_W      = 25;
    localparam int STRIDE_W    = 16;
    localparam int CFG_DIM_W   = 13;
    localparam int CFG_BLK_W   = 9;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_ADDR_W  = 3;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 56;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_TRANSPOSE  = 3'd0,
        CFG_ROWS       = 3'd1,
        CFG_COLS       = 3'd2,
        CFG_ROW_STRIDE = 3'd3,
        CFG_BLOCK_ROWS = 3'd4,
        CFG_BLOCK_COLS = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic pad;
        logic last;
    } t_walk_flags;

endpackage

// ===== hdl/blpa_walk.sv =====
// tile walk counters: current logical row and column, flags and destination index
module blpa_walk #(
    parameter int BASE_W = 13,
    parameter int DIM_W  = 13,
    parameter int BLK_W  = 9,
    parameter int ELEM_W = 8
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_clear,
    input  logic                    i_step,
    input  logic                    i_restart,
    input  logic [DIM_W-1:0]        i_m,
    input  logic [DIM_W-1:0]        i_n,
    input  logic [BLK_W-1:0]        i_bm,
    input  logic [BLK_W-1:0]        i_bn,
    output logic [BASE_W-1:0]       o_row,
    output logic [BASE_W-1:0]       o_col,
    output blpa_pkg::t_walk_flags   o_flags,
    output logic [blpa_pkg::DEST_W-1:0] o_dest
);
    import blpa_pkg::*;

    logic [BASE_W-1:0] r_tile_row, r_tile_col, n_tile_row, n_tile_col;
    logic [ELEM_W-1:0] r_elem_row, r_elem_col, n_elem_row, n_elem_col;
    logic [DEST_W-1:0] r_dest, n_dest;

    logic [BASE_W-1:0] w_tile_row, w_tile_col;
    logic [ELEM_W-1:0] w_elem_row, w_elem_col;
    logic [DEST_W-1:0] w_dest;
    logic [BLK_W-1:0]  w_elem_row_inc, w_elem_col_inc;
    logic [BASE_W:0]   w_tile_row_nxt, w_tile_col_nxt;
    logic              w_row_end, w_col_end, w_trow_end, w_tcol_end, w_last;

    // restart applies before this transaction is emitted
    assign w_tile_row = i_restart ? '0 : r_tile_row;
    assign w_tile_col = i_restart ? '0 : r_tile_col;
    assign w_elem_row = i_restart ? '0 : r_elem_row;
    assign w_elem_col = i_restart ? '0 : r_elem_col;
    assign w_dest     = i_restart ? '0 : r_dest;

    assign o_row  = w_tile_row + BASE_W'(w_elem_row);
    assign o_col  = w_tile_col + BASE_W'(w_elem_col);
    assign o_dest = w_dest;

    assign w_elem_row_inc = BLK_W'(w_elem_row) + BLK_W'(1);
    assign w_elem_col_inc = BLK_W'(w_elem_col) + BLK_W'(1);
    assign w_tile_row_nxt = (BASE_W+1)'(w_tile_row) + (BASE_W+1)'(i_bm);
    assign w_tile_col_nxt = (BASE_W+1)'(w_tile_col) + (BASE_W+1)'(i_bn);

    assign w_col_end  = w_elem_col_inc >= i_bn;
    assign w_row_end  = w_elem_row_inc >= i_bm;
    assign w_tcol_end = w_tile_col_nxt >= (BASE_W+1)'(i_n);
    assign w_trow_end = w_tile_row_nxt >= (BASE_W+1)'(i_m);
    assign w_last     = w_col_end && w_row_end && w_tcol_end && w_trow_end;

    assign o_flags.pad  = (o_row >= BASE_W'(i_m)) || (o_col >= BASE_W'(i_n));
    assign o_flags.last = w_last;

    always_comb begin
        n_tile_row = w_tile_row;
        n_tile_col = w_tile_col;
        n_elem_row = w_elem_row;
        n_elem_col = w_elem_col;
        n_dest     = w_dest + DEST_W'(1);
        priority if (w_last) begin
            n_tile_row = '0;
            n_tile_col = '0;
            n_elem_row = '0;
            n_elem_col = '0;
            n_dest     = '0;
        end else if (!w_col_end) begin
            n_elem_col = ELEM_W'(w_elem_col_inc);
        end else if (!w_row_end) begin
            n_elem_col = '0;
            n_elem_row = ELEM_W'(w_elem_row_inc);
        end else if (!w_tcol_end) begin
            n_elem_col = '0;
            n_elem_row = '0;
            n_tile_col = BASE_W'(w_tile_col_nxt);
        end else begin
            n_elem_col = '0;
            n_elem_row = '0;
            n_tile_col = '0;
            n_tile_row = BASE_W'(w_tile_row_nxt);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_tile_row <= '0;
            r_tile_col <= '0;
            r_elem_row <= '0;
            r_elem_col <= '0;
            r_dest     <= '0;
        end else if (i_step) begin
            r_tile_row <= n_tile_row;
            r_tile_col <= n_tile_col;
            r_elem_row <= n_elem_row;
            r_elem_col <= n_elem_col;
            r_dest     <= n_dest;
        end
    end

endmodule

// ===== hdl/blocked_layout_pack_address_gen.sv =====
// top level of the blocked layout pack address generator
//
//   channel | direction | handshake                     | contents
//   s_axis  | in        | s_axis_tvalid / s_axis_tready | restart
//   m_axis  | out       | m_axis_tvalid / m_axis_tready | source address, dest index, pad, last
//   cfg     | in        | i_cfg_we                      | register index and write data
//
// one transaction per cycle sustained while the output is not stalled; each input transaction
// passes the walk/flag stage, then one multiply-add stage into the output register
// reset returns the configuration registers to their defaults, clears the valid flags and the walk
// to the first element; a stalled output holds both stages; input is still taken while the first stage is free
// any configuration write restarts the walk
module blocked_layout_pack_address_gen #(
    parameter int MAX_DIM   = 4096,
    parameter int MAX_BLOCK = 256
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [blpa_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  logic [blpa_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [blpa_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // restart
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [blpa_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,  // source_address, dest_index
    output logic                               m_axis_tuser,  // pad
    output logic                               m_axis_tlast
);
    import blpa_pkg::*;

    localparam int DIM_W     = $clog2(MAX_DIM + 1);
    localparam int BLK_W     = $clog2(MAX_BLOCK + 1);
    localparam int ELEM_W    = $clog2(MAX_BLOCK);
    localparam int BASE_W    = $clog2(MAX_DIM + MAX_BLOCK);
    localparam int DIM_CMP_W = (DIM_W > CFG_DIM_W) ? DIM_W : CFG_DIM_W;
    localparam int BLK_CMP_W = (BLK_W > CFG_BLK_W) ? BLK_W : CFG_BLK_W;
    localparam int SUM_W     = (BASE_W + STRIDE_W + 1 > ADDR_W) ?
                               BASE_W + STRIDE_W + 1 : ADDR_W;

    // configuration, dimensions stored already saturated
    logic                r_transpose;
    logic [DIM_W-1:0]    r_m, r_n;
    logic [STRIDE_W-1:0] r_stride;
    logic [BLK_W-1:0]    r_bm, r_bn;

    logic [DIM_CMP_W-1:0] w_dim_in;
    logic [BLK_CMP_W-1:0] w_blk_in;
    logic [DIM_W-1:0]     w_dim_sat;
    logic [BLK_W-1:0]     w_blk_sat;

    assign w_dim_in  = DIM_CMP_W'(i_cfg_wdata[CFG_DIM_W-1:0]);
    assign w_blk_in  = BLK_CMP_W'(i_cfg_wdata[CFG_BLK_W-1:0]);
    assign w_dim_sat = (w_dim_in == '0) ? DIM_W'(1) :
                       (w_dim_in > DIM_CMP_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : DIM_W'(w_dim_in);
    assign w_blk_sat = (w_blk_in == '0) ? BLK_W'(1) :
                       (w_blk_in > BLK_CMP_W'(MAX_BLOCK)) ? BLK_W'(MAX_BLOCK) :
                       BLK_W'(w_blk_in);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_transpose <= 1'b0;
            r_m         <= DIM_W'(1);
            r_n         <= DIM_W'(1);
            r_stride    <= STRIDE_W'(1);
            r_bm        <= BLK_W'(1);
            r_bn        <= BLK_W'(1);
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_addr))
                CFG_TRANSPOSE:  r_transpose <= i_cfg_wdata[0];
                CFG_ROWS:       r_m         <= w_dim_sat;
                CFG_COLS:       r_n         <= w_dim_sat;
                CFG_ROW_STRIDE: r_stride    <= i_cfg_wdata[STRIDE_W-1:0];
                CFG_BLOCK_ROWS: r_bm        <= w_blk_sat;
                CFG_BLOCK_COLS: r_bn        <= w_blk_sat;
                default: ;
            endcase
        end
    end

    // handshake
    logic w_in_acc, w_out_free, w_s1_adv;
    logic r_s1_valid, r_out_valid;

    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_s1_adv      = r_s1_valid && w_out_free;
    assign s_axis_tready = !r_s1_valid || w_out_free;
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;

    // walk
    logic [BASE_W-1:0] w_row, w_col;
    t_walk_flags       w_flags;
    logic [DEST_W-1:0] w_dest;

    blpa_walk #(
        .BASE_W (BASE_W),
        .DIM_W  (DIM_W),
        .BLK_W  (BLK_W),
        .ELEM_W (ELEM_W)
    ) u_walk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clear   (i_cfg_we),
        .i_step    (w_in_acc),
        .i_restart (s_axis_tdata[0]),
        .i_m       (r_m),
        .i_n       (r_n),
        .i_bm      (r_bm),
        .i_bn      (r_bn),
        .o_row     (w_row),
        .o_col     (w_col),
        .o_flags   (w_flags),
        .o_dest    (w_dest)
    );

    // stage 1: multiplied index, added index, flags
    logic [BASE_W-1:0] r_s1_major, r_s1_minor;
    t_walk_flags       r_s1_flags;
    logic [DEST_W-1:0] r_s1_dest;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (w_s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s1_major <= r_transpose ? w_col : w_row;
            r_s1_minor <= r_transpose ? w_row : w_col;
            r_s1_flags <= w_flags;
            r_s1_dest  <= w_dest;
        end
    end

    // stage 2: address multiply-add into the output register
    logic [SUM_W-1:0]  w_addr_full;
    logic [ADDR_W-1:0] r_out_addr;
    logic [DEST_W-1:0] r_out_dest;
    t_walk_flags       r_out_flags;

    assign w_addr_full = SUM_W'(r_s1_major) * SUM_W'(r_stride) + SUM_W'(r_s1_minor);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_adv) begin
            r_out_addr  <= r_s1_flags.pad ? '0 : w_addr_full[ADDR_W-1:0];
            r_out_dest  <= r_s1_dest;
            r_out_flags <= r_s1_flags;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_TDATA_W'({r_out_dest, r_out_addr});
    assign m_axis_tuser  = r_out_flags.pad;
    assign m_axis_tlast  = r_out_flags.last;

    // checks
    a_pad_zero_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[ADDR_W-1:0] == '0))
        else $error("padded transaction carries a nonzero source address");

    a_full_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_out_valid && !m_axis_tready) |-> !s_axis_tready)
        else $error("input taken while both stages are held");

    a_cfg_restarts_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_cfg_we) && w_in_acc) |=> (r_s1_dest == '0))
        else $error("walk not restarted by configuration write");

    a_restart_dest_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && s_axis_tdata[0]) |=> (r_s1_dest == '0))
        else $error("restart transaction does not start at destination zero");

endmodule

// ===== verif/tb.sv =====
// testbench for the blocked layout pack address generator, checked against an in-bench walk model
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import blpa_pkg::*;

    localparam int MAX_DIM      = 4096;
    localparam int MAX_BLOCK    = 256;
    localparam int RANDOM_ITEMS = 1200;
    localparam int LIMIT        = 400000;

    localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_HI = 3'd7;

    typedef struct {
        logic [ADDR_W-1:0] addr;
        logic [DEST_W-1:0] dest;
        logic              pad;
        logic              last;
    } t_pack_elem;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0]  i_cfg_addr = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_wdata = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;   // restart
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;        // source_address, dest_index
    logic                   m_axis_tuser;        // pad
    logic                   m_axis_tlast;

    blocked_layout_pack_address_gen #(
        .MAX_DIM  (MAX_DIM),
        .MAX_BLOCK(MAX_BLOCK)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    // shadow registers and walk position
    logic                  c_transpose = 1'b0;
    logic [CFG_DIM_W-1:0]  c_rows = CFG_DIM_W'(1);
    logic [CFG_DIM_W-1:0]  c_cols = CFG_DIM_W'(1);
    logic [STRIDE_W-1:0]   c_stride = STRIDE_W'(1);
    logic [CFG_BLK_W-1:0]  c_brows = CFG_BLK_W'(1);
    logic [CFG_BLK_W-1:0]  c_bcols = CFG_BLK_W'(1);
    int unsigned           w_tile_row = 0;
    int unsigned           w_tile_col = 0;
    int unsigned           w_elem_row = 0;
    int unsigned           w_elem_col = 0;
    logic [DEST_W-1:0]     w_dest = '0;

    bit                    restart_queue[$];
    t_pack_elem            expected_elems[$];
    t_pack_elem            got_elem;
    int                    mismatches = 0;
    int                    burst_left = 1;
    int                    gap_left = 0;
    bit                    gaps_on = 1'b0;
    logic [15:0]           rdy_pattern = 16'hFFFF;
    int unsigned           cycle_count = 0;

    function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic void rewind_walk();
        w_tile_row = 0;
        w_tile_col = 0;
        w_elem_row = 0;
        w_elem_col = 0;
        w_dest     = '0;
    endfunction

    function automatic void apply_reg_write(input logic [CFG_ADDR_W-1:0] idx,
                                            input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_TRANSPOSE:  c_transpose = data[0];
            CFG_ROWS:       c_rows      = data[CFG_DIM_W-1:0];
            CFG_COLS:       c_cols      = data[CFG_DIM_W-1:0];
            CFG_ROW_STRIDE: c_stride    = data[STRIDE_W-1:0];
            CFG_BLOCK_ROWS: c_brows     = data[CFG_BLK_W-1:0];
            CFG_BLOCK_COLS: c_bcols     = data[CFG_BLK_W-1:0];
            default: ;
        endcase
        // every write, even to an unused index, restarts the walk
        rewind_walk();
    endfunction

    function automatic t_pack_elem next_pack_elem(input logic restart);
        int unsigned     m, n, bm, bn, tiles_m, tiles_n;
        longint unsigned r, c, a;
        t_pack_elem      e;
        m       = clamp_dim(c_rows, MAX_DIM);
        n       = clamp_dim(c_cols, MAX_DIM);
        bm      = clamp_dim(c_brows, MAX_BLOCK);
        bn      = clamp_dim(c_bcols, MAX_BLOCK);
        tiles_m = (m + bm - 1) / bm;
        tiles_n = (n + bn - 1) / bn;
        if (restart) rewind_walk();
        r = longint'(w_tile_row) * bm + w_elem_row;
        c = longint'(w_tile_col) * bn + w_elem_col;
        e.pad = (r >= m) || (c >= n);
        if (e.pad) a = 0;
        else if (c_transpose) a = c * c_stride + r;
        else a = r * c_stride + c;
        e.addr = a[ADDR_W-1:0];
        e.dest = w_dest;
        e.last = (w_tile_row + 1 >= tiles_m) && (w_tile_col + 1 >= tiles_n) &&
                 (w_elem_row + 1 >= bm) && (w_elem_col + 1 >= bn);
        if (e.last) begin
            rewind_walk();
        end else begin
            w_dest = w_dest + 1'b1;
            if (w_elem_col + 1 < bn) begin
                w_elem_col++;
            end else begin
                w_elem_col = 0;
                if (w_elem_row + 1 < bm) begin
                    w_elem_row++;
                end else begin
                    w_elem_row = 0;
                    if (w_tile_col + 1 < tiles_n) begin
                        w_tile_col++;
                    end else begin
                        w_tile_col = 0;
                        w_tile_row++;
                    end
                end
            end
        end
        return e;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] rand_dim();
        case ($urandom_range(0, 19))
            0:       return 16'd0;
            1:       return 16'd4096;
            2:       return 16'd4097;
            3:       return 16'hFFFF;
            4:       return 16'($urandom);
            5:       return 16'd4095;
            default: return 16'($urandom_range(1, 12));
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] rand_blk();
        case ($urandom_range(0, 19))
            0:       return 16'd0;
            1:       return 16'd256;
            2:       return 16'd257;
            3:       return 16'h01FF;
            4:       return 16'($urandom);
            5:       return 16'd255;
            default: return 16'($urandom_range(1, 6));
        endcase
    endfunction

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= data;
        apply_reg_write(idx, data);
    endtask

    task automatic close_writes();
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic drain();
        do @(negedge i_clk);
        while (restart_queue.size() != 0 || s_axis_tvalid || expected_elems.size() != 0);
    endtask

    // driver: one restart flag per transaction, bursts with random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                expected_elems.push_back(next_pack_elem(s_axis_tdata[0]));
            if (!s_axis_tvalid || s_axis_tready) begin
                if (gap_left > 0 || restart_queue.size() == 0) begin
                    if (gap_left > 0) gap_left--;
                    s_axis_tvalid <= 1'b0;
                end else begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= IN_TDATA_W'(restart_queue.pop_front());
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 16);
                        gap_left   = gaps_on ? $urandom_range(1, 8) : 0;
                    end
                end
            end
        end
    end

    // monitor: rotating ready pattern, compare against oldest expectation
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_elems.size() == 0) begin
                    if (mismatches < 10)
                        $display("unexpected transaction: addr %h dest %h pad %b last %b",
                                 m_axis_tdata[ADDR_W-1:0], m_axis_tdata[ADDR_W +: DEST_W],
                                 m_axis_tuser, m_axis_tlast);
                    mismatches++;
                end else begin
                    got_elem = expected_elems.pop_front();
                    if (m_axis_tdata[ADDR_W-1:0] !== got_elem.addr ||
                        m_axis_tdata[ADDR_W +: DEST_W] !== got_elem.dest ||
                        m_axis_tuser !== got_elem.pad || m_axis_tlast !== got_elem.last) begin
                        if (mismatches < 10)
                            $display({"mismatch: exp addr %h dest %h pad %b last %b, ",
                                      "got addr %h dest %h pad %b last %b"},
                                     got_elem.addr, got_elem.dest, got_elem.pad, got_elem.last,
                                     m_axis_tdata[ADDR_W-1:0], m_axis_tdata[ADDR_W +: DEST_W],
                                     m_axis_tuser, m_axis_tlast);
                        mismatches++;
                    end
                end
            end
            m_axis_tready <= rdy_pattern[0];
            rdy_pattern = {rdy_pattern[0], rdy_pattern[15:1]};
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT) begin
            $display("blocked_layout_pack_address_gen verification failed");
            $finish;
        end
    end

    initial begin
        int n_random;
        int n;
        int pct;
        bit wrote;
        n_random = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset defaults: a one-element matrix, every transaction is last
        restart_queue.push_back(1'b0);
        restart_queue.push_back(1'b1);
        restart_queue.push_back(1'b0);
        drain();

        // small transposed walk with padding, a restart midway and a wrap
        write_reg(CFG_TRANSPOSE, 16'd1);
        write_reg(CFG_ROWS, 16'd3);
        write_reg(CFG_COLS, 16'd2);
        write_reg(CFG_ROW_STRIDE, 16'd7);
        write_reg(CFG_BLOCK_ROWS, 16'd2);
        write_reg(CFG_BLOCK_COLS, 16'd2);
        close_writes();
        restart_queue.push_back(1'b0);
        restart_queue.push_back(1'b0);
        restart_queue.push_back(1'b1);
        repeat (8) restart_queue.push_back(1'b0);
        drain();

        // zero and oversized dimensions saturate, full-width stride
        write_reg(CFG_ROWS, 16'hFFFF);
        write_reg(CFG_COLS, 16'd0);
        write_reg(CFG_BLOCK_ROWS, 16'd0);
        write_reg(CFG_BLOCK_COLS, 16'h01FF);
        write_reg(CFG_ROW_STRIDE, 16'hFFFF);
        write_reg(CFG_TRANSPOSE, 16'd0);
        close_writes();
        restart_queue.push_back(1'b0);
        restart_queue.push_back(1'b0);
        restart_queue.push_back(1'b1);
        drain();

        // writes to unused indexes still restart the walk
        write_reg(CFG_SPARE_LO, 16'hFFFF);
        close_writes();
        restart_queue.push_back(1'b0);
        restart_queue.push_back(1'b0);
        drain();
        write_reg(CFG_SPARE_HI, 16'h0000);
        close_writes();
        restart_queue.push_back(1'b0);
        drain();

        while (n_random < RANDOM_ITEMS) begin
            gaps_on     = ($urandom_range(0, 9) < 7);
            rdy_pattern = ($urandom_range(0, 9) < 3) ? 16'hFFFF : (16'($urandom) | 16'h0001);
            wrote = 1'b0;
            if ($urandom_range(0, 9) < 7) begin
                write_reg(CFG_TRANSPOSE, 16'($urandom));
                wrote = 1'b1;
            end
            if ($urandom_range(0, 9) < 7) begin
                write_reg(CFG_ROWS, rand_dim());
                wrote = 1'b1;
            end
            if ($urandom_range(0, 9) < 7) begin
                write_reg(CFG_COLS, rand_dim());
                wrote = 1'b1;
            end
            if ($urandom_range(0, 9) < 7) begin
                case ($urandom_range(0, 9))
                    0:       write_reg(CFG_ROW_STRIDE, 16'd0);
                    1:       write_reg(CFG_ROW_STRIDE, 16'hFFFF);
                    2, 3, 4: write_reg(CFG_ROW_STRIDE, 16'($urandom));
                    default: write_reg(CFG_ROW_STRIDE, 16'($urandom_range(1, 20)));
                endcase
                wrote = 1'b1;
            end
            if ($urandom_range(0, 9) < 7) begin
                write_reg(CFG_BLOCK_ROWS, rand_blk());
                wrote = 1'b1;
            end
            if ($urandom_range(0, 9) < 7) begin
                write_reg(CFG_BLOCK_COLS, rand_blk());
                wrote = 1'b1;
            end
            if ($urandom_range(0, 9) == 0 || !wrote)
                write_reg($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI, 16'($urandom));
            close_writes();

            // mostly whole walks, some restart-heavy noise
            case ($urandom_range(0, 9))
                0, 1:    pct = 0;
                2:       pct = 40;
                default: pct = 2;
            endcase
            n = $urandom_range(20, 100);
            repeat (n) restart_queue.push_back($urandom_range(0, 99) < pct);
            n_random += n;
            drain();
        end

        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && expected_elems.size() == 0)
            $display("blocked_layout_pack_address_gen verification clean");
        else
            $display("blocked_layout_pack_address_gen verification failed");
        $finish;
    end

endmodule
